### design/ptd_pkg.sv
package ptd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS    = VALUE_BITS + 2;
    localparam int CNT_BITS   = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;

    localparam int FIRST_DIV  = 3;
    localparam int DIV_STEP   = 2;
    localparam int SMALLEST_PRIME = 2;
    localparam int FIRST_SQUARE   = 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOP = 3'b010,
        S_REM  = 3'b100
    } state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

### design/primality_trial_division.sv
// Channel   Ports                     Handshake
// request   value                     taken when start && !busy
// result    is_prime                  one-cycle strobe on done
//
// Values below four and even values are decided in S_LOOP without the remainder unit.
// Each odd trial divisor d (3, 5, ... while d*d <= value) runs through the
// bit-serial remainder unit, one quotient bit per cycle.
// Worst case for a 31-bit prime: about 23170 trial divisors.
// Asynchronous reset clears the sequencer; no result is pending after it.
// The receiver cannot stall: done lasts one cycle and busy drops with it.
module primality_trial_division (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ptd_pkg::VALUE_BITS-1:0] value,
    output logic                           busy,
    output logic                           done,
    output logic                           is_prime
);
    import ptd_pkg::*;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [DIV_BITS-1:0]   div_reg, div_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic                  done_reg, done_next;
    logic                  prime_reg, prime_next;
    logic                  rem_start;
    logic [SQ_BITS-1:0]    val_ext;
    rem_stat_t             rem_stat;

    assign val_ext = SQ_BITS'(val_reg);

    ptd_rem u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rem_start),
        .value   (val_reg),
        .divisor (div_reg),
        .stat    (rem_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        div_next   = div_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        rem_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next   = value;
                    div_next   = DIV_BITS'(FIRST_DIV);
                    sq_next    = SQ_BITS'(FIRST_DIV * FIRST_DIV);
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (val_ext < SQ_BITS'(SMALLEST_PRIME))
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = S_IDLE;
                end
                else if (val_ext < SQ_BITS'(FIRST_SQUARE))
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!val_reg[0])
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = S_IDLE;
                end
                else if (sq_reg > val_ext)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance to next odd divisor: (d+2)^2 = d^2 + 4d + 4
                        div_next   = div_reg + DIV_BITS'(DIV_STEP);
                        sq_next    = sq_reg + SQ_BITS'({div_reg, 2'b00})
                                   + SQ_BITS'(FIRST_SQUARE);
                        state_next = S_LOOP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule

### design/ptd_rem.sv
module ptd_rem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ptd_pkg::VALUE_BITS-1:0] value,
    input  logic [ptd_pkg::DIV_BITS-1:0]   divisor,
    output ptd_pkg::rem_stat_t           stat
);
    import ptd_pkg::*;

    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   div_reg, div_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;
    logic                  last;

    assign trial = {rem_reg, val_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign last  = (cnt_reg == CNT_BITS'(VALUE_BITS - 1));

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next = value;
            rem_next = '0;
            div_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            val_next = {val_reg[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = diff[DIV_BITS-1:0];
            else
                rem_next = trial[DIV_BITS-1:0];
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

### design/ptd_chk.sv
module ptd_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a request");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

endmodule

bind primality_trial_division ptd_chk u_ptd_chk (.*);
